>>> design/scp_pkg.sv
// Shared types, constants and helper functions of the serial command parser.
`default_nettype none
package scp_pkg;

   localparam int MAX_CHARS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_NUL     = 8'h00;

   localparam int KW_GO   = 0;
   localparam int KW_EXIT = 1;
   localparam int KW_POT  = 2;
   localparam int KW_HELP = 3;
   localparam int KW_COUNT = 4;
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd3, 3'd4};
   localparam logic [2:0] KW_POS_MAX = 3'd5;

   localparam logic [15:0] NUM_SAT     = 16'd32768;
   localparam logic [15:0] NUM_POS_MAX = 16'd32767;

   typedef enum logic [2:0] {
      KIND_GO_EXIT = 3'd0,
      KIND_POT     = 3'd1,
      KIND_CHOICE  = 3'd2,
      KIND_HELP    = 3'd3,
      KIND_UNKNOWN = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_SKIP1 = 3'd0,
      PH_TOK1  = 3'd1,
      PH_END1  = 3'd2,
      PH_SKIP2 = 3'd3,
      PH_TOK2  = 3'd4,
      PH_END2  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      NUM_SKIP   = 2'd0,
      NUM_DIGITS = 2'd1,
      NUM_DONE   = 2'd2
   } num_phase_type;

   typedef enum logic [2:0] {
      CC_COLON = 3'd0,
      CC_DIGIT = 3'd1,
      CC_SPACE = 3'd2,
      CC_PLUS  = 3'd3,
      CC_MINUS = 3'd4,
      CC_OTHER = 3'd5
   } char_class_type;

   // One queued event: either a line character or the end of the line.
   typedef struct packed {
      logic           eol;
      logic [7:0]     ch;
      char_class_type cls;
   } event_type;

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type r;
      if (c == CH_COLON) begin
         r = CC_COLON;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         r = CC_DIGIT;
      end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
         r = CC_SPACE;
      end else if (c == CH_PLUS) begin
         r = CC_PLUS;
      end else if (c == CH_MINUS) begin
         r = CC_MINUS;
      end else begin
         r = CC_OTHER;
      end
      return r;
   endfunction

   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
      logic [7:0] r;
      r = CH_NUL;
      unique case (k)
         2'd0: begin
            case (pos)
               3'd0: r = 8'h67;
               3'd1: r = 8'h6F;
               default: r = CH_NUL;
            endcase
         end
         2'd1: begin
            case (pos)
               3'd0: r = 8'h65;
               3'd1: r = 8'h78;
               3'd2: r = 8'h69;
               3'd3: r = 8'h74;
               default: r = CH_NUL;
            endcase
         end
         2'd2: begin
            case (pos)
               3'd0: r = 8'h70;
               3'd1: r = 8'h6F;
               3'd2: r = 8'h74;
               default: r = CH_NUL;
            endcase
         end
         default: begin
            case (pos)
               3'd0: r = 8'h68;
               3'd1: r = 8'h65;
               3'd2: r = 8'h6C;
               3'd3: r = 8'h70;
               default: r = CH_NUL;
            endcase
         end
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/scp_front.sv
// Front end: frames the line, counts characters and classifies each byte.
`default_nettype none
module scp_front #(
   parameter int MAX_CHARS = scp_pkg::MAX_CHARS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_rx_byte,
   input  wire logic                q_full,
   output logic                     q_push,
   output scp_pkg::event_type       q_event
);

   localparam int COUNT_W = $clog2(MAX_CHARS);
   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(MAX_CHARS - 1);

   logic               receiving_ff, receiving_in;
   logic               ended_ff, ended_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               accept;
   logic               is_eol;
   logic               take_char;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_eol    = (req_rx_byte == scp_pkg::CH_NEWLINE);
   assign take_char = !ended_ff && (count_ff != LAST_COUNT);

   always_comb begin
      receiving_in = receiving_ff;
      ended_in     = ended_ff;
      count_in     = count_ff;
      q_push       = 1'b0;
      if (accept) begin
         if (!receiving_ff) begin
            if (req_rx_byte == scp_pkg::CH_BANG) begin
               receiving_in = 1'b1;
            end
         end else if (is_eol) begin
            q_push       = 1'b1;
            receiving_in = 1'b0;
            ended_in     = 1'b0;
            count_in     = '0;
         end else if (take_char) begin
            count_in = count_ff + 1'b1;
            // A zero byte ends the text but is never parsed.
            if (req_rx_byte == scp_pkg::CH_NUL) begin
               ended_in = 1'b1;
            end else begin
               q_push = 1'b1;
            end
         end
      end
   end

   always_comb begin
      q_event.eol = is_eol;
      q_event.ch  = req_rx_byte;
      q_event.cls = scp_pkg::classify(req_rx_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         ended_ff     <= 1'b0;
         count_ff     <= '0;
      end else begin
         receiving_ff <= receiving_in;
         ended_ff     <= ended_in;
         count_ff     <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> design/scp_queue.sv
// Two-entry event queue between the front end and the parser.
`default_nettype none
module scp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire scp_pkg::event_type push_event,
   output logic                    full,
   output logic                    head_valid,
   output scp_pkg::event_type      head_event,
   input  wire logic               pop
);

   localparam int CNT_W = $clog2(scp_pkg::QUEUE_DEPTH + 1);
   localparam int PTR_W = $clog2(scp_pkg::QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH = CNT_W'(scp_pkg::QUEUE_DEPTH);

   scp_pkg::event_type entries_ff [scp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == DEPTH);
   assign head_valid = (count_ff != '0);
   assign head_event = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule
`default_nettype wire

>>> design/scp_back.sv
// Back end: streaming token and number parser with the result register.
`default_nettype none
module scp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire scp_pkg::event_type head_event,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_command_kind,
   output logic [2:0]              rsp_choice_index,
   output logic signed [15:0]      rsp_pot_value
);

   scp_pkg::phase_type     phase_ff, phase_in;
   logic [2:0]             kw_pos_ff, kw_pos_in;
   logic [3:0]             kw_cand_ff, kw_cand_in;
   scp_pkg::num_phase_type num_phase_ff, num_phase_in;
   logic                   num_neg_ff, num_neg_in;
   logic [15:0]            num_val_ff, num_val_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   scp_pkg::kind_type      kind_ff, kind_in;
   logic [2:0]             choice_ff, choice_in;
   logic [15:0]            pot_ff, pot_in;

   logic                   out_free;
   logic                   pop_char, pop_eol;
   logic                   is_colon;
   logic [3:0]             full;

   // Candidate next values of the keyword matcher and the number reader.
   logic [2:0]             kw_pos_step;
   logic [3:0]             kw_cand_step;
   scp_pkg::num_phase_type num_phase_step;
   logic                   num_neg_step;
   logic [15:0]            num_val_step;
   logic                   digit_stage;
   logic [19:0]            acc;
   logic [15:0]            pot_num;
   logic                   choice_ok;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head_valid && (!head_event.eol || out_free);
   assign pop_char = pop && !head_event.eol;
   assign pop_eol  = pop && head_event.eol;
   assign is_colon = (head_event.cls == scp_pkg::CC_COLON);

   always_comb begin
      for (int k = 0; k < scp_pkg::KW_COUNT; k++) begin
         full[k] = kw_cand_ff[k] && (kw_pos_ff == scp_pkg::KW_LEN[k]);
         kw_cand_step[k] = kw_cand_ff[k] && (kw_pos_ff < scp_pkg::KW_LEN[k]) &&
                           (scp_pkg::kw_char(2'(k), kw_pos_ff) == head_event.ch);
      end
      kw_pos_step = (kw_pos_ff < scp_pkg::KW_POS_MAX) ? kw_pos_ff + 3'd1 : kw_pos_ff;
   end

   always_comb begin
      num_phase_step = num_phase_ff;
      num_neg_step   = num_neg_ff;
      num_val_step   = num_val_ff;
      digit_stage    = (num_phase_ff == scp_pkg::NUM_DIGITS);
      acc            = {4'd0, num_val_ff} * 20'd10 + 20'(head_event.ch - scp_pkg::CH_ZERO);
      if (num_phase_ff == scp_pkg::NUM_SKIP) begin
         case (head_event.cls)
            scp_pkg::CC_SPACE: begin
            end
            scp_pkg::CC_PLUS: begin
               num_phase_step = scp_pkg::NUM_DIGITS;
            end
            scp_pkg::CC_MINUS: begin
               num_phase_step = scp_pkg::NUM_DIGITS;
               num_neg_step   = 1'b1;
            end
            default: begin
               // Any other character is the first candidate digit.
               num_phase_step = scp_pkg::NUM_DIGITS;
               digit_stage    = 1'b1;
            end
         endcase
      end
      if (digit_stage) begin
         if (head_event.cls == scp_pkg::CC_DIGIT) begin
            num_val_step = (acc > {4'd0, scp_pkg::NUM_SAT}) ? scp_pkg::NUM_SAT : acc[15:0];
         end else begin
            num_phase_step = scp_pkg::NUM_DONE;
         end
      end
   end

   // Next state of the token sequencer and its datapath.
   always_comb begin
      logic feed_kw;
      logic feed_num;
      logic clear_num;
      feed_kw   = 1'b0;
      feed_num  = 1'b0;
      clear_num = 1'b0;
      phase_in  = phase_ff;
      if (pop_char) begin
         unique case (phase_ff)
            scp_pkg::PH_SKIP1: begin
               if (!is_colon) begin
                  phase_in = scp_pkg::PH_TOK1;
                  feed_kw  = 1'b1;
                  feed_num = 1'b1;
               end
            end
            scp_pkg::PH_TOK1: begin
               if (is_colon) begin
                  if (full[scp_pkg::KW_POT]) begin
                     phase_in  = scp_pkg::PH_SKIP2;
                     clear_num = 1'b1;
                  end else begin
                     phase_in = scp_pkg::PH_END1;
                  end
               end else begin
                  feed_kw  = 1'b1;
                  feed_num = 1'b1;
               end
            end
            scp_pkg::PH_SKIP2: begin
               if (!is_colon) begin
                  phase_in = scp_pkg::PH_TOK2;
                  feed_num = 1'b1;
               end
            end
            scp_pkg::PH_TOK2: begin
               if (is_colon) begin
                  phase_in = scp_pkg::PH_END2;
               end else begin
                  feed_num = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      kw_pos_in    = feed_kw ? kw_pos_step : kw_pos_ff;
      kw_cand_in   = feed_kw ? kw_cand_step : kw_cand_ff;
      num_phase_in = feed_num ? num_phase_step : num_phase_ff;
      num_neg_in   = feed_num ? num_neg_step : num_neg_ff;
      num_val_in   = feed_num ? num_val_step : num_val_ff;
      if (clear_num || pop_eol) begin
         num_phase_in = scp_pkg::NUM_SKIP;
         num_neg_in   = 1'b0;
         num_val_in   = '0;
      end
      if (pop_eol) begin
         phase_in   = scp_pkg::PH_SKIP1;
         kw_pos_in  = '0;
         kw_cand_in = 4'hF;
      end
   end

   // Result of the line as it stands, and the output register.
   always_comb begin
      pot_num   = num_neg_ff ? 16'(-num_val_ff) :
                  ((num_val_ff > scp_pkg::NUM_POS_MAX) ? scp_pkg::NUM_POS_MAX : num_val_ff);
      choice_ok = !num_neg_ff && (num_val_ff >= 16'd1) && (num_val_ff <= 16'd8);
      kind_in   = scp_pkg::KIND_UNKNOWN;
      choice_in = '0;
      pot_in    = '0;
      unique case (phase_ff)
         scp_pkg::PH_SKIP2: begin
            kind_in = scp_pkg::KIND_POT;
         end
         scp_pkg::PH_TOK2, scp_pkg::PH_END2: begin
            kind_in = scp_pkg::KIND_POT;
            pot_in  = pot_num;
         end
         scp_pkg::PH_TOK1, scp_pkg::PH_END1: begin
            if (full[scp_pkg::KW_GO] || full[scp_pkg::KW_EXIT]) begin
               kind_in = scp_pkg::KIND_GO_EXIT;
            end else if (full[scp_pkg::KW_POT]) begin
               kind_in = scp_pkg::KIND_POT;
            end else if (full[scp_pkg::KW_HELP]) begin
               kind_in = scp_pkg::KIND_HELP;
            end else if (choice_ok) begin
               kind_in   = scp_pkg::KIND_CHOICE;
               choice_in = 3'(num_val_ff - 16'd1);
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = pop_eol ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= scp_pkg::PH_SKIP1;
         kw_pos_ff    <= '0;
         kw_cand_ff   <= 4'hF;
         num_phase_ff <= scp_pkg::NUM_SKIP;
         num_neg_ff   <= 1'b0;
         num_val_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kw_pos_ff    <= kw_pos_in;
         kw_cand_ff   <= kw_cand_in;
         num_phase_ff <= num_phase_in;
         num_neg_ff   <= num_neg_in;
         num_val_ff   <= num_val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_eol) begin
         kind_ff   <= kind_in;
         choice_ff <= choice_in;
         pot_ff    <= pot_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_kind = kind_ff;
   assign rsp_choice_index = choice_ff;
   assign rsp_pot_value    = $signed(pot_ff);

endmodule
`default_nettype wire

>>> design/serial_command_parser.sv
// Top level of the serial command parser: front end, event queue and parser.
//
//   beat       direction  ports
//   request    in         req_valid, req_stall, req_rx_byte
//   response   out        rsp_valid, rsp_stall, rsp_command_kind, rsp_choice_index,
//                         rsp_pot_value
//
// One byte beat is taken per cycle unless stalled; a newline is queued, then registered.
// The front end gates and classifies bytes and writes events into a two-entry queue.
// The parser retires one event per cycle; a newline waits only while the response
// register is full and stalled, and req_stall rises only when the queue is full.
// Reset is synchronous and clears the line framing, the queue and the parser state.
`default_nettype none
module serial_command_parser #(
   parameter int MAX_CHARS = scp_pkg::MAX_CHARS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_command_kind,
   output logic [2:0]              rsp_choice_index,
   output logic signed [15:0]      rsp_pot_value
);

   logic               q_full;
   logic               q_push;
   scp_pkg::event_type q_event;
   logic               head_valid;
   scp_pkg::event_type head_event;
   logic               pop;

   scp_front #(
      .MAX_CHARS(MAX_CHARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_rx_byte(req_rx_byte),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_event    (q_event)
   );

   scp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_event(q_event),
      .full      (q_full),
      .head_valid(head_valid),
      .head_event(head_event),
      .pop       (pop)
   );

   scp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_event      (head_event),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_command_kind(rsp_command_kind),
      .rsp_choice_index(rsp_choice_index),
      .rsp_pot_value   (rsp_pot_value)
   );

endmodule
`default_nettype wire

>>> design/scp_checker.sv
// Port-level checks of the serial command parser and their binding.
`default_nettype none
module scp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [2:0]         rsp_command_kind,
   input wire logic [2:0]         rsp_choice_index,
   input wire logic signed [15:0] rsp_pot_value
);

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command_kind) &&
      $stable(rsp_choice_index) && $stable(rsp_pot_value))
      else $error("response changed while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_command_kind <= 3'(scp_pkg::KIND_UNKNOWN))
      else $error("command kind out of range");

   a_choice_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_kind != 3'(scp_pkg::KIND_CHOICE) |-> rsp_choice_index == 3'd0)
      else $error("choice index set for a non-choice command");

   a_pot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_kind != 3'(scp_pkg::KIND_POT) |-> rsp_pot_value == 16'sd0)
      else $error("pot value set for a non-pot command");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

endmodule

bind serial_command_parser scp_checker u_scp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_command_kind(rsp_command_kind),
   .rsp_choice_index(rsp_choice_index),
   .rsp_pot_value   (rsp_pot_value)
);
`default_nettype wire

>>> test/serial_command_parser_test.sv
// Self-checking testbench for the serial command parser with randomized stimulus and stalls.
`timescale 1ns / 100ps
module serial_command_parser_test;

   localparam int LINE_CHARS = scp_pkg::MAX_CHARS_DEFAULT;
   localparam int RANDOM_BYTES = 1600;
   localparam int CALM_TAIL = 150;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER_BYTES = 600;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      scp_pkg::kind_type  kind;
      logic [2:0]         choice;
      logic signed [15:0] pot;
   } command_result_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_rx_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_command_kind;
   logic [2:0]        rsp_choice_index;
   logic signed [15:0] rsp_pot_value;

   logic [7:0]         pending_bytes[$];
   command_result_type expected_cmds[$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            bytes_taken = 0;
   logic          winding_down = 1'b0;
   int            send_gap = 0;
   int            send_rate = 0;
   int            recv_gap = 0;
   int            recv_rate = 0;
   int            hold_left = 0;
   bit            hold_done = 0;

   string keyword_text[scp_pkg::KW_COUNT] = '{"go", "exit", "pot", "help"};

   // Shadow copy of the parser state.
   bit                     line_open;
   int unsigned            line_chars;
   bit                     text_ended;
   scp_pkg::phase_type     tok_phase;
   int unsigned            kw_pos;
   logic [3:0]             kw_live;
   scp_pkg::num_phase_type num_phase;
   bit                     num_neg;
   int unsigned            num_mag;

   serial_command_parser #(.MAX_CHARS(LINE_CHARS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_command_kind(rsp_command_kind),
      .rsp_choice_index(rsp_choice_index),
      .rsp_pot_value(rsp_pot_value)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // ---------------- predictor ----------------

   task automatic clear_number();
      num_phase = scp_pkg::NUM_SKIP;
      num_neg = 1'b0;
      num_mag = 0;
   endtask

   task automatic clear_line();
      line_chars = 0;
      text_ended = 1'b0;
      tok_phase = scp_pkg::PH_SKIP1;
      kw_pos = 0;
      kw_live = 4'hF;
      clear_number();
   endtask

   function automatic bit keyword_done(input int k);
      return kw_live[k] && kw_pos == keyword_text[k].len();
   endfunction

   function automatic int number_value();
      if (num_neg) begin
         return -int'(num_mag);
      end
      return (num_mag > scp_pkg::NUM_POS_MAX) ? int'(scp_pkg::NUM_POS_MAX) : int'(num_mag);
   endfunction

   task automatic feed_number(input logic [7:0] c);
      if (num_phase == scp_pkg::NUM_SKIP) begin
         if (c == scp_pkg::CH_SPACE || (c >= scp_pkg::CH_TAB && c <= scp_pkg::CH_CR)) begin
            return;
         end
         if (c == scp_pkg::CH_PLUS) begin
            num_phase = scp_pkg::NUM_DIGITS;
            return;
         end
         if (c == scp_pkg::CH_MINUS) begin
            num_phase = scp_pkg::NUM_DIGITS;
            num_neg = 1'b1;
            return;
         end
         num_phase = scp_pkg::NUM_DIGITS;
      end
      if (num_phase == scp_pkg::NUM_DIGITS) begin
         if (c >= scp_pkg::CH_ZERO && c <= scp_pkg::CH_NINE) begin
            num_mag = num_mag * 10 + (c - scp_pkg::CH_ZERO);
            if (num_mag > scp_pkg::NUM_SAT) begin
               num_mag = scp_pkg::NUM_SAT;
            end
         end else begin
            num_phase = scp_pkg::NUM_DONE;
         end
      end
   endtask

   // A character of the first token: it narrows the keyword candidates and feeds the number.
   task automatic feed_first(input logic [7:0] c);
      if (c == scp_pkg::CH_COLON) begin
         if (keyword_done(scp_pkg::KW_POT)) begin
            tok_phase = scp_pkg::PH_SKIP2;
            clear_number();
         end else begin
            tok_phase = scp_pkg::PH_END1;
         end
         return;
      end
      for (int k = 0; k < scp_pkg::KW_COUNT; k++) begin
         if (kw_live[k] && !(kw_pos < keyword_text[k].len() && keyword_text[k][kw_pos] == c)) begin
            kw_live[k] = 1'b0;
         end
      end
      if (kw_pos < scp_pkg::KW_POS_MAX) begin
         kw_pos++;
      end
      feed_number(c);
   endtask

   task automatic feed_line_char(input logic [7:0] c);
      case (tok_phase)
         scp_pkg::PH_SKIP1: begin
            if (c != scp_pkg::CH_COLON) begin
               tok_phase = scp_pkg::PH_TOK1;
               feed_first(c);
            end
         end
         scp_pkg::PH_TOK1: begin
            feed_first(c);
         end
         scp_pkg::PH_SKIP2: begin
            if (c != scp_pkg::CH_COLON) begin
               tok_phase = scp_pkg::PH_TOK2;
               feed_number(c);
            end
         end
         scp_pkg::PH_TOK2: begin
            if (c == scp_pkg::CH_COLON) begin
               tok_phase = scp_pkg::PH_END2;
            end else begin
               feed_number(c);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic track_byte(input logic [7:0] c);
      command_result_type r;
      int v;
      if (!line_open) begin
         if (c == scp_pkg::CH_BANG) begin
            line_open = 1'b1;
         end
      end else if (c != scp_pkg::CH_NEWLINE) begin
         if (!text_ended && line_chars < LINE_CHARS - 1) begin
            line_chars++;
            if (c == scp_pkg::CH_NUL) begin
               text_ended = 1'b1;
            end else begin
               feed_line_char(c);
            end
         end
      end else begin
         r.kind = scp_pkg::KIND_UNKNOWN;
         r.choice = 3'd0;
         r.pot = 16'sd0;
         case (tok_phase)
            scp_pkg::PH_SKIP2: begin
               r.kind = scp_pkg::KIND_POT;
            end
            scp_pkg::PH_TOK2, scp_pkg::PH_END2: begin
               v = number_value();
               r.kind = scp_pkg::KIND_POT;
               r.pot = v[15:0];
            end
            scp_pkg::PH_TOK1, scp_pkg::PH_END1: begin
               v = number_value();
               if (keyword_done(scp_pkg::KW_GO) || keyword_done(scp_pkg::KW_EXIT)) begin
                  r.kind = scp_pkg::KIND_GO_EXIT;
               end else if (keyword_done(scp_pkg::KW_POT)) begin
                  r.kind = scp_pkg::KIND_POT;
               end else if (keyword_done(scp_pkg::KW_HELP)) begin
                  r.kind = scp_pkg::KIND_HELP;
               end else if (v >= 1 && v < 9) begin
                  r.kind = scp_pkg::KIND_CHOICE;
                  r.choice = 3'(v - 1);
               end
            end
            default: begin
            end
         endcase
         expected_cmds.push_back(r);
         line_open = 1'b0;
         clear_line();
      end
   endtask

   // ---------------- stimulus ----------------

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(s[i]);
      end
   endtask

   task automatic push_printable(input int count);
      repeat (count) push_byte(8'($urandom_range(32, 126)));
   endtask

   // Whitespace, an optional sign and a run of digits, sometimes long enough to saturate.
   task automatic push_number_text();
      int n;
      n = $urandom_range(0, 2);
      repeat (n) begin
         if ($urandom_range(0, 5) == 0) begin
            push_byte(scp_pkg::CH_SPACE);
         end else begin
            push_byte(8'($urandom_range(scp_pkg::CH_TAB, scp_pkg::CH_CR)));
         end
      end
      case ($urandom_range(0, 3))
         0: push_byte(scp_pkg::CH_PLUS);
         1: push_byte(scp_pkg::CH_MINUS);
         default: begin
         end
      endcase
      case ($urandom_range(0, 3))
         0, 1: begin
            push_byte(8'($urandom_range(scp_pkg::CH_ZERO + 1, scp_pkg::CH_ZERO + 8)));
            n = 0;
         end
         2: n = $urandom_range(0, 4);
         default: n = $urandom_range(5, 8);
      endcase
      if (n > 0) begin
         repeat (n) push_byte(8'($urandom_range(scp_pkg::CH_ZERO, scp_pkg::CH_NINE)));
      end
      if ($urandom_range(0, 2) == 0) begin
         push_printable(1);
      end
   endtask

   task automatic push_tail();
      case ($urandom_range(0, 3))
         0: begin
            push_byte(scp_pkg::CH_COLON);
            push_printable($urandom_range(0, 4));
         end
         1: push_printable($urandom_range(1, 3));
         default: begin
         end
      endcase
   endtask

   task automatic push_random_line();
      string w;
      int n;
      int p;
      if ($urandom_range(0, 7) == 0) begin
         // Noise before the line opens; a stray newline here is ignored too.
         repeat ($urandom_range(1, 3)) begin
            n = $urandom_range(0, 255);
            push_byte(n == scp_pkg::CH_BANG ? scp_pkg::CH_NEWLINE : n[7:0]);
         end
      end
      push_byte(scp_pkg::CH_BANG);
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) push_byte(scp_pkg::CH_COLON);
      end
      w = keyword_text[$urandom_range(0, scp_pkg::KW_COUNT - 1)];
      case ($urandom_range(0, 9))
         0: begin
            push_text(w);
            push_tail();
         end
         1: begin
            push_text("pot");
            repeat ($urandom_range(0, 3)) push_byte(scp_pkg::CH_COLON);
            if ($urandom_range(0, 5) != 0) begin
               push_number_text();
            end
            push_tail();
         end
         2, 3: begin
            push_number_text();
            push_tail();
         end
         4: begin
            // Keyword cut short or running on.
            n = $urandom_range(1, w.len());
            for (int i = 0; i < n; i++) begin
               push_byte(w[i]);
            end
            if ($urandom_range(0, 1) == 1) begin
               push_printable(1);
            end
         end
         5: push_printable($urandom_range(0, 8));
         6: repeat ($urandom_range(0, 12)) push_byte(8'($urandom_range(0, 255)));
         7: begin
            repeat ($urandom_range(26, 40)) begin
               if ($urandom_range(0, 1) == 1) begin
                  push_byte(scp_pkg::CH_COLON);
               end else begin
                  push_printable(1);
               end
            end
            push_text(w);
         end
         8: begin
            p = $urandom_range(0, w.len());
            for (int i = 0; i < w.len(); i++) begin
               if (i == p) begin
                  push_byte(scp_pkg::CH_NUL);
               end
               push_byte(w[i]);
            end
            if (p == w.len()) begin
               push_byte(scp_pkg::CH_NUL);
            end
            push_tail();
         end
         default: repeat ($urandom_range(0, 3)) push_byte(scp_pkg::CH_COLON);
      endcase
      push_byte(scp_pkg::CH_NEWLINE);
   endtask

   task automatic push_directed();
      push_text("zz\n");
      push_text("!go\n");
      push_text("!exit\n");
      push_text("!::help:more\n");
      push_text("!pot:1234\n");
      push_text("!pot\n");
      push_text("!pot:::\n");
      push_text("!pot:: \t-42:junk\n");
      push_text("!pot:99999\n");
      push_text("!pot:-99999\n");
      push_text("!pot:-32768\n");
      push_text("!pot:+32767x\n");
      push_text("!1\n");
      push_text("!8\n");
      push_text("!9\n");
      push_text("!0\n");
      push_text("! \v+3x\n");
      push_text("!\n");
      push_text("!:::\n");
      push_text("!!go\n");
      push_text("!gox\n");
      push_text("!go:xyz\n");
      push_text("!g");
      push_byte(scp_pkg::CH_NUL);
      push_text("o\n");
      // Colons fill the line so that only the first keyword letter counts, then both letters.
      push_byte(scp_pkg::CH_BANG);
      repeat (LINE_CHARS - 2) push_byte(scp_pkg::CH_COLON);
      push_text("go\n");
      push_byte(scp_pkg::CH_BANG);
      repeat (LINE_CHARS - 3) push_byte(scp_pkg::CH_COLON);
      push_text("go\n");
      push_byte(scp_pkg::CH_BANG);
      push_byte(8'hFF);
      push_byte(8'h80);
      push_byte(scp_pkg::CH_NEWLINE);
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'h00;
         winding_down <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            track_byte(req_rx_byte);
            bytes_taken <= bytes_taken + 1;
         end
         winding_down <= pending_bytes.size() < CALM_TAIL;
         if (cycle_count % 200 == 0) begin
            send_rate = $urandom_range(0, 3);
         end
         // A stalled beat stays on the bus unchanged.
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_valid <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
               if (!winding_down && send_rate != 0 && $urandom_range(0, 6 * send_rate) == 0) begin
                  send_gap = $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- long receiver hold-off ----------------

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && bytes_taken >= HOLD_AFTER_BYTES) begin
         // Long hold-off so the input side backs up and stalls.
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin : watch_responses
      command_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               report_mismatch($sformatf("unexpected response kind %0d", rsp_command_kind));
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_command_kind !== want.kind) begin
                  report_mismatch($sformatf("command_kind %0d, expected %0d",
                                            rsp_command_kind, want.kind));
               end
               if (rsp_choice_index !== want.choice) begin
                  report_mismatch($sformatf("choice_index %0d, expected %0d",
                                            rsp_choice_index, want.choice));
               end
               if (rsp_pot_value !== want.pot) begin
                  report_mismatch($sformatf("pot_value %0d, expected %0d",
                                            rsp_pot_value, want.pot));
               end
            end
         end
         if (cycle_count % 200 == 100) begin
            recv_rate = $urandom_range(0, 3);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (!winding_down && recv_rate != 0 && $urandom_range(0, 6 * recv_rate) == 0) begin
            recv_gap = $urandom_range(0, 9);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------- sequence and end of run ----------------

   initial begin
      line_open = 1'b0;
      clear_line();
      push_directed();
      while (pending_bytes.size() < RANDOM_BYTES) begin
         push_random_line();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_bytes.size() == 0 && !req_valid);
      wait (expected_cmds.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_cmds.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
